// ===== hw/rtl/rtlp_pkg.sv =====
// Shared types and constants for the reader line parser with CRC16 frame check.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package rtlp_pkg;

    // Default longest line, CR and LF included.
    localparam int MAX_LINE_DEF = 256;

    // CRC16-CCITT settings.
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_TOP       = 16'h8000;
    localparam logic [15:0] RESIDUE_RESET = 16'h1D0F;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_U  = 8'h55;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_TAG_READ = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // Command passed from the front end to the back end for one byte.
    // ovf: the line overflowed. eol: CR LF ended the line.
    // cr_char: a held CR turned out to be an ordinary character.
    // byte_char: the byte itself is a content character.
    typedef struct packed {
        logic       ovf;
        logic       eol;
        logic       cr_char;
        logic       byte_char;
        logic [7:0] ch;
    } t_cmd;

endpackage

// ===== hw/rtl/rtlp_front.sv =====
// Front end: accepts received bytes, counts line length, holds CR and classifies each byte.
// Depends on rtlp_pkg.
module rtlp_front #(
    parameter int MAX_LINE = rtlp_pkg::MAX_LINE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_q_full,
    output logic           o_push,
    output rtlp_pkg::t_cmd o_cmd
);
    import rtlp_pkg::*;

    localparam int LW = $clog2(MAX_LINE + 2);

    logic [LW-1:0] r_len, n_len;
    logic          r_held, n_held;
    logic [LW-1:0] len_inc;
    logic          accept;
    t_cmd          cmd;

    // Classify the byte against the held CR and the line length.
    always_comb begin
        accept = i_in_valid & ~i_q_full;
        len_inc = r_len + 1'b1;
        n_len = r_len;
        n_held = r_held;
        cmd = '0;
        cmd.ch = i_rx_byte;
        if (accept) begin
            n_len = len_inc;
            if (len_inc > LW'(MAX_LINE)) begin
                cmd.ovf = 1'b1;
                n_len = '0;
                n_held = 1'b0;
            end else if (r_held && i_rx_byte == CH_LF) begin
                cmd.eol = 1'b1;
                n_len = '0;
                n_held = 1'b0;
            end else begin
                cmd.cr_char = r_held;
                n_held = (i_rx_byte == CH_CR);
                cmd.byte_char = (i_rx_byte != CH_CR);
            end
        end
    end

    assign o_in_stall = i_q_full;
    assign o_cmd = cmd;
    assign o_push = accept & (cmd.ovf | cmd.eol | cmd.cr_char | cmd.byte_char);

    // Line length and held CR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_held <= 1'b0;
        end else begin
            r_len <= n_len;
            r_held <= n_held;
        end
    end

endmodule

// ===== hw/rtl/rtlp_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on rtlp_pkg.
module rtlp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rtlp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rtlp_pkg::t_cmd o_cmd
);
    import rtlp_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_slot[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/rtlp_back.sv =====
// Back end: parses content characters, decodes hex, runs the CRC, builds the EPC
// and holds the result register. Depends on rtlp_pkg.
module rtlp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_q_valid,
    input  rtlp_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_status,
    output logic [31:0]    o_epc_upper,
    output logic [63:0]    o_epc_lower
);
    import rtlp_pkg::*;

    localparam logic [5:0] FRAME_CHARS = 6'd32;

    typedef struct packed {
        logic       started;
        logic       is_u;
        logic       long_en;
        logic [5:0] off;
        logic [3:0] hn;
    } t_line;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // Lenient nibble decode; the result may exceed 15.
    function automatic logic [7:0] nib(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v;
    endfunction

    // One content character; reports a completed frame byte, if any.
    function automatic void char_step(input t_line s, input logic [7:0] c,
                                      output t_line o, output logic take,
                                      output logic [7:0] b, output logic [4:0] idx);
        logic [7:0] n;
        logic       ws;
        n = nib(c);
        ws = is_ws(c);
        o = s;
        take = 1'b0;
        b = '0;
        idx = '0;
        if (!s.started) begin
            if (!ws) begin
                o.started = 1'b1;
                o.is_u = (c == CH_U);
                o.off = 6'd1;
            end
        end else begin
            if (s.off >= 6'd1 && s.off <= FRAME_CHARS) begin
                if (s.off[0]) begin
                    o.hn = n[3:0];
                end else begin
                    take = 1'b1;
                    b = {s.hn, 4'b0000} | n;
                    idx = s.off[5:1] - 5'd1;
                end
            end
            if (!ws && s.off >= FRAME_CHARS) begin
                o.long_en = 1'b1;
            end
            if (s.off <= FRAME_CHARS) begin
                o.off = s.off + 6'd1;
            end
        end
    endfunction

    // Eight CRC bit steps for one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    t_line        r_line, n_line;
    logic [15:0]  r_crc, n_crc;
    logic [15:0]  r_residue;
    logic [31:0]  r_epc_hi;
    logic [63:0]  r_epc_lo;
    logic         r_out_valid;
    t_status      r_status;
    logic [31:0]  r_out_hi;
    logic [63:0]  r_out_lo;

    t_line        line_a, line_b, line_mid;
    logic         take_a, take_b, take;
    logic [7:0]   byte_a, byte_b, tbyte;
    logic [4:0]   idx_a, idx_b, tidx;
    logic         eol_emits, emit, pop;
    t_status      status;

    // Apply the held CR, then the byte, as content characters.
    always_comb begin
        char_step(r_line, CH_CR, line_a, take_a, byte_a, idx_a);
        line_mid = i_cmd.cr_char ? line_a : r_line;
        char_step(line_mid, i_cmd.ch, line_b, take_b, byte_b, idx_b);
        take = (i_cmd.cr_char & take_a) | (i_cmd.byte_char & take_b);
        tbyte = (i_cmd.cr_char & take_a) ? byte_a : byte_b;
        tidx = (i_cmd.cr_char & take_a) ? idx_a : idx_b;
    end

    // Decide whether this command yields a result and whether it may retire.
    always_comb begin
        eol_emits = r_line.started & (~r_line.is_u | r_line.long_en);
        emit = i_q_valid & (i_cmd.ovf | (i_cmd.eol & eol_emits));
        pop = i_q_valid & (~emit | ~r_out_valid | ~i_out_stall);
        if (i_cmd.ovf) begin
            status = ST_OVERFLOW;
        end else if (!r_line.is_u) begin
            status = ST_UNKNOWN;
        end else if (r_crc != r_residue) begin
            status = ST_CRC_ERR;
        end else begin
            status = ST_TAG_READ;
        end
    end

    // Next line state and CRC.
    always_comb begin
        n_line = r_line;
        n_crc = r_crc;
        if (pop) begin
            if (i_cmd.ovf || i_cmd.eol) begin
                n_line = '0;
                n_crc = CRC_INIT;
            end else begin
                n_line = i_cmd.byte_char ? line_b : line_mid;
                if (take) begin
                    n_crc = crc_byte(r_crc, tbyte);
                end
            end
        end
    end

    assign o_pop = pop;

    // Control state, residue register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_crc <= CRC_INIT;
            r_residue <= RESIDUE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_line <= n_line;
            r_crc <= n_crc;
            if (i_cfg_we) begin
                r_residue <= i_cfg_data;
            end
            if (pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // EPC shift registers and result payload.
    always_ff @(posedge i_clk) begin
        if (pop && !i_cmd.ovf && !i_cmd.eol && take) begin
            if (tidx >= 5'd2 && tidx <= 5'd5) begin
                r_epc_hi <= {r_epc_hi[23:0], tbyte};
            end else if (tidx >= 5'd6 && tidx <= 5'd13) begin
                r_epc_lo <= {r_epc_lo[55:0], tbyte};
            end
        end
        if (pop && emit) begin
            r_status <= status;
            r_out_hi <= (status == ST_TAG_READ) ? r_epc_hi : 32'h0;
            r_out_lo <= (status == ST_TAG_READ) ? r_epc_lo : 64'h0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_status;
    assign o_epc_upper = r_out_hi;
    assign o_epc_lower = r_out_lo;

endmodule

// ===== hw/rtl/rfid_tag_line_parser_crc_core.sv =====
// Reader line parser with CRC16-CCITT frame check. Takes one received byte per
// transfer at up to one byte per clock cycle, sustained while the output does not stall.
// Lines end at CR LF; a line whose first non-blank character is 'U' carries 32 hex
// characters that decode to 16 frame bytes, checked with CRC16-CCITT (init 0xFFFF,
// poly 0x1021) against the crc_residue register (reset 0x1D0F). A good line gives the
// 96-bit EPC (frame bytes 2 to 13); a bad one gives a CRC error, an unknown frame or
// a line overflow status. The LF transfer writes the two-entry command queue; the
// back end then writes the result to the output register, when that register is free.
// The back end does one byte-wide CRC step per cycle while the output does not stall.
module rfid_tag_line_parser_crc_core #(
    parameter int MAX_LINE = rtlp_pkg::MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_epc_upper,
    output logic [63:0] o_epc_lower
);
    import rtlp_pkg::*;

    logic q_full, push, pop, q_valid;
    t_cmd f_cmd, q_cmd;

    // Byte intake and classification.
    rtlp_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_rx_byte(i_rx_byte),
        .i_q_full(q_full),
        .o_push(push),
        .o_cmd(f_cmd)
    );

    // Decoupling queue.
    rtlp_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_cmd(f_cmd),
        .o_full(q_full),
        .i_pop(pop),
        .o_valid(q_valid),
        .o_cmd(q_cmd)
    );

    // Parsing, CRC and result register.
    rtlp_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_q_valid(q_valid),
        .i_cmd(q_cmd),
        .o_pop(pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_epc_upper(o_epc_upper),
        .o_epc_lower(o_epc_lower)
    );

endmodule
